[hdl/usdt_pkg.sv]
// ----------------------------------------------------------------------------
// usdt_pkg: shared types and constants for the sum decomposition table
// Field widths, result codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package usdt_pkg;

    // default sizes, overridable on the top level
    localparam int SUM_LIMIT_DEF = 32768;
    localparam int MAX_ITEMS_DEF = 32;

    // fixed field widths
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 15;
    localparam int WAYS_W   = 2;

    // saturating counts
    localparam logic [WAYS_W-1:0]  WAYS_NONE = 2'd0;
    localparam logic [WAYS_W-1:0]  WAYS_ONE  = 2'd1;
    localparam logic [WAYS_W-1:0]  WAYS_SAT  = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7fff;

    // input action codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_IMPOSSIBLE = 3'd0,
        ST_UNIQUE     = 3'd1,
        ST_AMBIGUOUS  = 3'd2,
        ST_RANGE      = 3'd3,
        ST_ADDED      = 3'd4,
        ST_FULL       = 3'd5
    } usdt_status_t;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ADD,
        S_QLOOK,
        S_WALK_LI,
        S_WALK_UPD,
        S_WALK_RD,
        S_SCAN,
        S_EMIT,
        S_RESULT
    } usdt_state_t;

    // controller to datapath
    typedef struct packed {
        logic         clr_step;
        logic         load;
        logic         add_start;
        logic         add_step;
        logic         set_code;
        usdt_status_t code;
        logic         vld_clear;
        logic         walk_k;
        logic         walk_upd;
        logic         scan_rd;
        logic         scan_next;
        logic         emit_item;
        logic         emit_code;
    } usdt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              is_query;
        logic              full;
        logic              in_range;
        logic              clr_last;
        logic              add_done;
        logic [WAYS_W-1:0] ways;
        logic              q_zero;
        logic              li_stop;
        logic              walk_stop;
        logic              scan_end;
        logic              scan_hit;
        logic              emit_last;
        logic              out_free;
    } usdt_sts_t;

endpackage

[hdl/usdt_ctrl.sv]
// ----------------------------------------------------------------------------
// usdt_ctrl: sequencing controller
// Steps through the clearing pass, the add pass, the query walk back and the
// result scan, driving the datapath by command bundle.
// ----------------------------------------------------------------------------
module usdt_ctrl
    import usdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  usdt_sts_t sts,
    output usdt_cmd_t cmd
);

    usdt_state_t state_reg;
    usdt_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_IMPOSSIBLE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.set_code = 1'b1;
                if (!sts.is_query)
                begin
                    if (sts.full)
                    begin
                        cmd.code   = ST_FULL;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.add_start = 1'b1;
                        cmd.code      = ST_ADDED;
                        state_next    = sts.in_range ? S_ADD : S_RESULT;
                    end
                end
                else if (!sts.in_range)
                begin
                    cmd.code   = ST_RANGE;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_QLOOK;
                end
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (sts.add_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_QLOOK:
            begin
                if (sts.ways == WAYS_NONE)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_IMPOSSIBLE;
                    state_next   = S_RESULT;
                end
                else if (sts.ways >= WAYS_SAT)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_AMBIGUOUS;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.vld_clear = 1'b1;
                    state_next    = sts.q_zero ? S_SCAN : S_WALK_LI;
                end
            end
            S_WALK_LI:
            begin
                if (sts.li_stop)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.walk_k = 1'b1;
                    state_next = S_WALK_UPD;
                end
            end
            S_WALK_UPD:
            begin
                cmd.walk_upd = 1'b1;
                state_next   = sts.walk_stop ? S_SCAN : S_WALK_RD;
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_LI;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_end)
                begin
                    // nothing tallied: sum zero
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_UNIQUE;
                    state_next   = S_RESULT;
                end
                else if (sts.scan_hit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_EMIT:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.out_free)
                begin
                    cmd.emit_item = 1'b1;
                    cmd.scan_next = 1'b1;
                    state_next    = sts.emit_last ? S_IDLE : S_SCAN;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_code = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/usdt_dp.sv]
// ----------------------------------------------------------------------------
// usdt_dp: table datapath
// Holds the ways/last-item table, the cost and tally stores, the walk and
// scan counters and the output register.
// ----------------------------------------------------------------------------
module usdt_dp
    import usdt_pkg::*;
#(
    parameter int SUM_LIMIT = SUM_LIMIT_DEF,
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  usdt_cmd_t           cmd,
    output usdt_sts_t           sts,
    input  logic                action,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [INDEX_W-1:0]  item_index,
    output logic [COUNT_W-1:0]  item_count,
    output logic                last_result
);

    localparam int ADDR_W = $clog2(SUM_LIMIT);
    localparam int JW     = ADDR_W + 1;
    localparam int LI_W   = $clog2(MAX_ITEMS + 1);
    localparam int KW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int SI_W   = KW + 1;
    localparam int ME_W   = WAYS_W + LI_W;
    localparam int VX_W   = VALUE_W + 1;

    // stores
    logic [ME_W-1:0]    tbl_mem   [SUM_LIMIT];
    logic [VALUE_W-1:0] cost_mem  [MAX_ITEMS];
    logic [COUNT_W-1:0] tally_mem [MAX_ITEMS];

    // item and counters
    logic               action_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [ADDR_W-1:0]  q_reg,  q_next;
    logic [JW-1:0]      j_reg,  j_next;
    logic [LI_W-1:0]    items_reg, items_next;
    logic [KW-1:0]      k_reg;
    logic [MAX_ITEMS-1:0] vld_reg, vld_next;
    logic [SI_W-1:0]    i_reg, i_next;
    usdt_status_t       code_reg;

    // add pipeline
    logic               p_vld_reg, p_vld_next;
    logic [ADDR_W-1:0]  p_addr_reg;
    logic               fwd_vld_reg;
    logic [WAYS_W-1:0]  fwd_ways_reg;

    // memory ports
    logic [ADDR_W-1:0]  rda_addr, rdb_addr, wr_addr;
    logic [ME_W-1:0]    rda_reg, rdb_reg, wr_data;
    logic               wr_en;
    logic [VALUE_W-1:0] cost_rd_reg;
    logic [COUNT_W-1:0] tally_rd_reg;
    logic [KW-1:0]      tally_addr;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                last_reg;

    // derived values
    logic [ADDR_W-1:0]  c_lo, j_lo;
    logic               j_live;
    logic [WAYS_W-1:0]  prev_ways, cur_ways, new_ways;
    logic [LI_W-1:0]    new_li, li;
    logic [WAYS_W:0]    sum_ways;
    logic [KW-1:0]      li_k;
    logic [COUNT_W-1:0] tally_inc;
    logic [MAX_ITEMS-1:0] above;

    assign c_lo   = value_reg[ADDR_W-1:0];
    assign j_lo   = j_reg[ADDR_W-1:0];
    assign j_live = (j_reg < JW'(SUM_LIMIT));
    assign li     = rdb_reg[LI_W-1:0];
    assign li_k   = KW'(li - LI_W'(1));

    // table read addresses: add pass source and current entry, or queried sum
    assign rda_addr = j_lo - c_lo;
    assign rdb_addr = cmd.add_step ? j_lo : q_reg;

    // add pass, second stage: merge source count into current entry
    always_comb
    begin
        if (fwd_vld_reg && (c_lo == ADDR_W'(1)))
        begin
            prev_ways = fwd_ways_reg;
        end
        else
        begin
            prev_ways = rda_reg[ME_W-1 -: WAYS_W];
        end
        cur_ways = rdb_reg[ME_W-1 -: WAYS_W];
        sum_ways = {1'b0, cur_ways} + {1'b0, prev_ways};
        new_ways = cur_ways;
        new_li   = li;
        if (prev_ways != WAYS_NONE)
        begin
            if (sum_ways >= {1'b0, WAYS_SAT})
            begin
                new_ways = WAYS_SAT;
                new_li   = '0;
            end
            else if (sum_ways == {1'b0, WAYS_ONE})
            begin
                new_ways = WAYS_ONE;
                new_li   = items_reg;
            end
        end
    end

    // table write port: clearing pass or add pass
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = p_addr_reg;
        wr_data = {new_ways, new_li};
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = j_lo;
            wr_data = (j_reg == '0) ? {WAYS_ONE, LI_W'(0)} : '0;
        end
        else if (p_vld_reg)
        begin
            wr_en = 1'b1;
        end
    end

    // table memory, two registered reads and one write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        rda_reg <= tbl_mem[rda_addr];
        rdb_reg <= tbl_mem[rdb_addr];
    end

    // tally increment, saturating
    always_comb
    begin
        if (!vld_reg[k_reg])
        begin
            tally_inc = COUNT_W'(1);
        end
        else if (tally_rd_reg == COUNT_MAX)
        begin
            tally_inc = tally_rd_reg;
        end
        else
        begin
            tally_inc = tally_rd_reg + COUNT_W'(1);
        end
    end

    assign tally_addr = cmd.scan_rd ? i_reg[KW-1:0] : li_k;

    // cost and tally stores
    always_ff @(posedge clk)
    begin
        if (cmd.add_start)
        begin
            cost_mem[KW'(items_reg)] <= value_reg;
        end
        if (cmd.walk_upd)
        begin
            tally_mem[k_reg] <= tally_inc;
        end
        cost_rd_reg  <= cost_mem[li_k];
        tally_rd_reg <= tally_mem[tally_addr];
    end

    // tallied items above the scan index
    always_comb
    begin
        for (int b = 0; b < MAX_ITEMS; b++)
        begin
            above[b] = (SI_W'(b) > i_reg) ? vld_reg[b] : 1'b0;
        end
    end

    // counter next values
    always_comb
    begin
        j_next     = j_reg;
        p_vld_next = cmd.add_step && j_live;
        items_next = items_reg;
        q_next     = q_reg;
        vld_next   = vld_reg;
        i_next     = i_reg;
        if (cmd.clr_step || (cmd.add_step && j_live))
        begin
            j_next = j_reg + JW'(1);
        end
        else if (cmd.add_start)
        begin
            j_next = JW'(value_reg);
        end
        if (cmd.add_start)
        begin
            items_next = items_reg + LI_W'(1);
        end
        if (cmd.load)
        begin
            q_next = value[ADDR_W-1:0];
        end
        else if (cmd.walk_upd && !sts.walk_stop)
        begin
            q_next = q_reg - cost_rd_reg[ADDR_W-1:0];
        end
        if (cmd.vld_clear)
        begin
            vld_next = '0;
            i_next   = '0;
        end
        else
        begin
            if (cmd.walk_upd)
            begin
                vld_next[k_reg] = 1'b1;
            end
            if (cmd.scan_next)
            begin
                i_next = i_reg + SI_W'(1);
            end
        end
    end

    // output register next
    always_comb
    begin
        if (cmd.emit_item || cmd.emit_code)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg         <= '0;
            items_reg     <= '0;
            p_vld_reg     <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            vld_reg       <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            j_reg         <= j_next;
            items_reg     <= items_next;
            p_vld_reg     <= p_vld_next;
            fwd_vld_reg   <= p_vld_reg;
            vld_reg       <= vld_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        p_addr_reg   <= j_lo;
        fwd_ways_reg <= new_ways;
        if (cmd.load)
        begin
            action_reg <= action;
            value_reg  <= value;
        end
        if (cmd.walk_k)
        begin
            k_reg <= li_k;
        end
        if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end
        if (cmd.emit_item)
        begin
            status_reg <= ST_UNIQUE;
            index_reg  <= INDEX_W'(i_reg + SI_W'(1));
            count_reg  <= tally_rd_reg;
            last_reg   <= sts.emit_last;
        end
        else if (cmd.emit_code)
        begin
            status_reg <= code_reg;
            index_reg  <= (code_reg == ST_ADDED) ? INDEX_W'(items_reg) : '0;
            count_reg  <= '0;
            last_reg   <= 1'b1;
        end
    end

    // status to the controller
    always_comb
    begin
        sts.is_query  = (action_reg == ACT_QUERY);
        sts.full      = (items_reg == LI_W'(MAX_ITEMS));
        sts.in_range  = ({1'b0, value_reg} < VX_W'(SUM_LIMIT));
        sts.clr_last  = (j_reg == JW'(SUM_LIMIT - 1));
        sts.add_done  = !j_live && !p_vld_reg;
        sts.ways      = rdb_reg[ME_W-1 -: WAYS_W];
        sts.q_zero    = (q_reg == '0);
        sts.li_stop   = (li == '0) || (li > items_reg);
        sts.walk_stop = (cost_rd_reg == '0) || (cost_rd_reg >= VALUE_W'(q_reg));
        sts.scan_end  = (i_reg == SI_W'(MAX_ITEMS));
        sts.scan_hit  = !sts.scan_end && vld_reg[i_reg[KW-1:0]];
        sts.emit_last = ~|above;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign item_index  = index_reg;
    assign item_count  = count_reg;
    assign last_result = last_reg;

endmodule

[hdl/unique_sum_decomposition_table_core.sv]
// ----------------------------------------------------------------------------
// unique_sum_decomposition_table_core: saturating coin-change table
// Keeps per-sum decomposition counts over item costs, adds items with one
// ascending pass over the table and answers sum queries with a walk back.
//
//   channel | beat fields                                 | handshake
//   --------+---------------------------------------------+-------------------
//   input   | action, value                               | in_valid/in_ready
//   output  | status, item_index, item_count, last_result | out_valid/out_ready
//
// After reset a clearing pass writes every table entry, with in_ready low.
// Add: one table entry per cycle through the two-read, one-write table
// memory, from the cost up to the top of the table; a full table or an
// oversized cost skips the pass.
// Query: a lookup, then a walk back through WALK_LI, WALK_UPD and
// WALK_RD per step, then a scan of the MAX_ITEMS item slots with one
// beat delivered per tallied item.
// The output register lets the next beat be taken while the last one waits;
// a stalled output holds the scan until the register frees.
// ----------------------------------------------------------------------------
module unique_sum_decomposition_table_core
    import usdt_pkg::*;
#(
    parameter int SUM_LIMIT = SUM_LIMIT_DEF,
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [INDEX_W-1:0]  item_index,
    output logic [COUNT_W-1:0]  item_count,
    output logic                last_result
);

    usdt_cmd_t cmd;
    usdt_sts_t sts;

    // sequencing
    usdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores and arithmetic
    usdt_dp #(
        .SUM_LIMIT (SUM_LIMIT),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (action),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .item_index  (item_index),
        .item_count  (item_count),
        .last_result (last_result)
    );

`ifndef ASSERT_OFF
    // a result is never loaded over one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_item || cmd.emit_code) |-> sts.out_free)
        else $error("result loaded into a busy output register");

    // an accepted beat takes the controller out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after accepting a beat");

    // no table or walk activity while waiting for input
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.clr_step || cmd.add_step || cmd.walk_upd || cmd.emit_item))
        else $error("datapath active while idle");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sum decomposition table core
// Drives add and query beats through the valid/ready input and keeps its own
// saturating coin-change table alongside the block. Every output beat is
// checked field by field against the oldest predicted beat. Sender bursts and
// receiver stalls vary at random throughout the run.
// ----------------------------------------------------------------------------
module testbench;
    import usdt_pkg::*;

    localparam int SUM_LIMIT     = SUM_LIMIT_DEF;
    localparam int MAX_ITEMS     = MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS  = 50;
    localparam int SMALL_ADDS    = 8;
    localparam int ADD_CEILING   = 28;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 10000000;

    // one output beat
    typedef struct packed {
        usdt_status_t       status;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic               last;
    } decomp_beat_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                action    = ACT_ADD;
    logic [VALUE_W-1:0]  value     = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  item_index;
    logic [COUNT_W-1:0]  item_count;
    logic                last_result;

    // shadow copy of the block's table
    logic [WAYS_W-1:0]   sum_ways [SUM_LIMIT];
    logic [INDEX_W-1:0]  sum_last_item [SUM_LIMIT];
    logic [VALUE_W-1:0]  item_cost [MAX_ITEMS];
    int unsigned         loaded_items;

    decomp_beat_t        pending_beats [$];
    int unsigned         error_count   = 0;
    int unsigned         cycle_count   = 0;
    int unsigned         burst_left    = 0;
    int unsigned         small_adds_left;
    int                  ready_mode      = 0;
    int unsigned         ready_mode_left = 0;

    unique_sum_decomposition_table_core #(
        .SUM_LIMIT (SUM_LIMIT),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .item_index  (item_index),
        .item_count  (item_count),
        .last_result (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------
    task automatic clear_table();
        for (int j = 0; j < SUM_LIMIT; j++)
        begin
            sum_ways[j]      = WAYS_NONE;
            sum_last_item[j] = '0;
        end
        for (int k = 0; k < MAX_ITEMS; k++)
            item_cost[k] = '0;
        sum_ways[0]  = WAYS_ONE;
        loaded_items = 0;
    endtask

    // append one predicted beat to the tail of the expected queue
    task automatic queue_beat(input decomp_beat_t beat);
        pending_beats.insert(pending_beats.size(), beat);
    endtask

    // register an item and run the ascending pass
    task automatic register_item(input logic [VALUE_W-1:0] cost);
        decomp_beat_t beat;
        int unsigned  prev;
        int unsigned  total;
        beat = '{status: ST_FULL, index: '0, count: '0, last: 1'b1};
        if (loaded_items < MAX_ITEMS)
        begin
            item_cost[loaded_items] = cost;
            loaded_items++;
            for (int j = cost; j < SUM_LIMIT; j++)
            begin
                prev = sum_ways[j - cost];
                if (prev != 0)
                begin
                    total = sum_ways[j] + prev;
                    if (total >= WAYS_SAT)
                    begin
                        sum_ways[j]      = WAYS_SAT;
                        sum_last_item[j] = '0;
                    end
                    else if (total == 1)
                    begin
                        sum_ways[j]      = WAYS_ONE;
                        sum_last_item[j] = loaded_items[INDEX_W-1:0];
                    end
                end
            end
            beat.status = ST_ADDED;
            beat.index  = loaded_items[INDEX_W-1:0];
        end
        queue_beat(beat);
    endtask

    // classify a sum and, when unique, walk back to the items used
    task automatic resolve_sum(input logic [VALUE_W-1:0] sum);
        decomp_beat_t beat;
        decomp_beat_t found [$];
        logic [COUNT_W-1:0] usage [MAX_ITEMS];
        int unsigned  remainder;
        int unsigned  slot;
        int unsigned  cost;
        beat = '{status: ST_UNIQUE, index: '0, count: '0, last: 1'b1};
        if (sum >= SUM_LIMIT)
            beat.status = ST_RANGE;
        else if (sum_ways[sum] == WAYS_NONE)
            beat.status = ST_IMPOSSIBLE;
        else if (sum_ways[sum] >= WAYS_SAT)
            beat.status = ST_AMBIGUOUS;
        else
        begin
            for (int k = 0; k < MAX_ITEMS; k++)
                usage[k] = '0;
            remainder = sum;
            for (int steps = 0; steps < SUM_LIMIT && remainder > 0; steps++)
            begin
                slot = sum_last_item[remainder];
                if (slot == 0 || slot > loaded_items || slot > MAX_ITEMS)
                    break;
                if (usage[slot - 1] < COUNT_MAX)
                    usage[slot - 1]++;
                cost = item_cost[slot - 1];
                if (cost == 0 || cost > remainder)
                    break;
                remainder -= cost;
            end
            for (int k = 0; k < MAX_ITEMS; k++)
            begin
                if (usage[k] != 0)
                    found.insert(found.size(),
                                 '{status: ST_UNIQUE, index: INDEX_W'(k + 1),
                                   count: usage[k], last: 1'b0});
            end
        end
        if (found.size() == 0)
            queue_beat(beat);
        else
        begin
            found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                queue_beat(found[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: one beat, then either carry on the burst or idle a while
    // ------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [VALUE_W-1:0] val);
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act == ACT_ADD)
            register_item(val);
        else
            resolve_sum(val);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes mode every so often
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode      = $urandom_range(0, 2);
            ready_mode_left = $urandom_range(10, 300);
        end
        else
            ready_mode_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_beat
        decomp_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected beat status %0d index %0d count %0d last %0d",
                         $time, status, item_index, item_count, last_result);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, status);
                end
                if (item_index !== want.index)
                begin
                    error_count++;
                    $display("%0t: item_index expected %0d, got %0d",
                             $time, want.index, item_index);
                end
                if (item_count !== want.count)
                begin
                    error_count++;
                    $display("%0t: item_count expected %0d, got %0d",
                             $time, want.count, item_count);
                end
                if (last_result !== want.last)
                begin
                    error_count++;
                    $display("%0t: last_result expected %0d, got %0d",
                             $time, want.last, last_result);
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // only sum zero reachable straight after reset
    task automatic test_empty_table();
        send_item(ACT_QUERY, 16'd0);
        send_item(ACT_QUERY, 16'd1);
        send_item(ACT_QUERY, 16'(SUM_LIMIT - 1));
        send_item(ACT_QUERY, 16'(SUM_LIMIT));
        send_item(ACT_QUERY, 16'hffff);
    endtask

    // a few small costs: unique, ambiguous and impossible sums
    task automatic test_small_items();
        send_item(ACT_ADD, 16'd6);
        send_item(ACT_ADD, 16'd10);
        send_item(ACT_ADD, 16'd15);
        send_item(ACT_QUERY, 16'd0);
        send_item(ACT_QUERY, 16'd6);
        send_item(ACT_QUERY, 16'd12);
        send_item(ACT_QUERY, 16'd16);
        send_item(ACT_QUERY, 16'd21);
        send_item(ACT_QUERY, 16'd25);
        send_item(ACT_QUERY, 16'd31);
        send_item(ACT_QUERY, 16'd30);
        send_item(ACT_QUERY, 16'd7);
        send_item(ACT_QUERY, 16'd45);
    endtask

    // costs at and past the top of the table
    task automatic test_oversized_costs();
        send_item(ACT_ADD, 16'd40000);
        send_item(ACT_ADD, 16'(SUM_LIMIT));
        send_item(ACT_ADD, 16'hffff);
        send_item(ACT_ADD, 16'(SUM_LIMIT - 1));
        send_item(ACT_QUERY, 16'(SUM_LIMIT - 1));
        send_item(ACT_QUERY, 16'(SUM_LIMIT - 2));
    endtask

    // a sum built from a few loaded costs, so most queries hit reachable sums
    function automatic logic [VALUE_W-1:0] combo_sum();
        int unsigned total;
        int unsigned k;
        total = 0;
        repeat ($urandom_range(1, 3))
        begin
            k = $urandom_range(0, loaded_items - 1);
            if (item_cost[k] < 4096)
                total += item_cost[k] * $urandom_range(1, 3);
        end
        return VALUE_W'(total);
    endfunction

    task automatic test_random_mix();
        int unsigned        roll;
        logic [VALUE_W-1:0] val;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12 && loaded_items < ADD_CEILING)
            begin
                // full passes are slow, so only a handful of small costs
                if (small_adds_left > 0 && $urandom_range(0, 1) == 1)
                begin
                    val = VALUE_W'($urandom_range(1, 400));
                    small_adds_left--;
                end
                else if ($urandom_range(0, 1) == 1)
                    val = VALUE_W'($urandom_range(30000, SUM_LIMIT - 1));
                else
                    val = VALUE_W'($urandom_range(SUM_LIMIT, 65535));
                send_item(ACT_ADD, val);
            end
            else
            begin
                if (roll < 60)
                    val = combo_sum();
                else if (roll < 75)
                    val = VALUE_W'($urandom_range(0, 255));
                else if (roll < 85)
                    val = VALUE_W'($urandom_range(0, SUM_LIMIT - 1));
                else if (roll < 93)
                    val = VALUE_W'($urandom_range(SUM_LIMIT, 65535));
                else
                    val = VALUE_W'($urandom_range(SUM_LIMIT - 2, SUM_LIMIT + 1));
                send_item(ACT_QUERY, val);
            end
        end
    endtask

    // a zero cost makes every reachable sum ambiguous
    task automatic test_zero_cost();
        send_item(ACT_ADD, 16'd0);
        send_item(ACT_QUERY, 16'd0);
        send_item(ACT_QUERY, 16'd1);
        send_item(ACT_QUERY, 16'd6);
        send_item(ACT_QUERY, 16'(SUM_LIMIT - 1));
        send_item(ACT_QUERY, 16'd40000);
    endtask

    // fill the item store with cheap out-of-table costs, then overflow it
    task automatic test_table_full();
        while (loaded_items < MAX_ITEMS)
            send_item(ACT_ADD, 16'($urandom_range(SUM_LIMIT, 65535)));
        send_item(ACT_ADD, 16'd0);
        send_item(ACT_ADD, 16'hffff);
        send_item(ACT_QUERY, 16'd0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_table();
        small_adds_left = SMALL_ADDS;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_small_items();
        test_oversized_costs();
        test_random_mix();
        test_zero_cost();
        test_table_full();

        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
hdl/usdt_pkg.sv
hdl/usdt_ctrl.sv
hdl/usdt_dp.sv
hdl/unique_sum_decomposition_table_core.sv
tb/testbench.sv
